// ----- sv/lrgd_pkg.sv -----
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared constants, codes and controller/datapath interface types for the
// logistic regression gradient step block.
// ----------------------------------------------------------------------------
package lrgd_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   // error (18 bit) times feature (16 bit), summed over every point
   localparam int GRAD_W     = 34 + CNT_W;
   // one cost term stays below 2^21
   localparam int COST_W     = (21 + CNT_W > 33) ? 21 + CNT_W : 33;

   localparam int LOG_ITERS  = 16;
   localparam int SQRT_ITERS = 32;
   localparam int DIV_ITERS  = 54;
   localparam int ITER_W     = 6;

   localparam logic [15:0] LN2_Q16 = 16'd45426;

   localparam logic [15:0] LEARN_RATE_RESET  = 16'd655;
   localparam logic [31:0] INIT_WEIGHT_RESET = 32'd33554432;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_STEP  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_LEARN_RATE  = 2'd0,
      CSR_INIT_BIAS   = 2'd1,
      CSR_INIT_ONE    = 2'd2,
      CSR_INIT_TWO    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              load;
      logic              clear;
      logic              acc_clear;
      logic              mem_read;
      logic              mul1;
      logic              mul2;
      logic              zsum;
      logic              sig;
      logic              grad1;
      logic              grad2;
      logic              log_iter;
      logic              log_acc;
      logic              mag_init;
      logic              mag_shift;
      logic              sq_acc;
      logic              sqrt_init;
      logic              sqrt_iter;
      logic              div_init;
      logic              div_iter;
      logic              update;
      logic              out_load;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        sel;
   } lrgd_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             max_big;
      logic             grad_zero;
   } lrgd_status_type;

endpackage

// ----- sv/lrgd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrgd_ctrl
// Sequencer for load, clear and gradient step words; issues datapath commands.
// ----------------------------------------------------------------------------
module lrgd_ctrl import lrgd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_opcode,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  lrgd_status_type status,
   output lrgd_cmd_type    cmd
);

   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_READ   = 19'h00002,
      S_MUL1   = 19'h00004,
      S_MUL2   = 19'h00008,
      S_ZSUM   = 19'h00010,
      S_SIG    = 19'h00020,
      S_GRAD1  = 19'h00040,
      S_GRAD2  = 19'h00080,
      S_LOGIT  = 19'h00100,
      S_LOGACC = 19'h00200,
      S_MAG    = 19'h00400,
      S_SHIFT  = 19'h00800,
      S_SQ     = 19'h01000,
      S_SQRTI  = 19'h02000,
      S_SQRT   = 19'h04000,
      S_DIVI   = 19'h08000,
      S_DIV    = 19'h10000,
      S_UPD    = 19'h20000,
      S_OUT    = 19'h40000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ITER_W-1:0] it_ff, it_in;
   logic [1:0]        sel_ff, sel_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      it_in     = it_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.addr  = idx_ff[ADDR_W-1:0];
      cmd.sel   = sel_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_opcode)
                  OP_LOAD:  cmd.load  = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_STEP: begin
                     cmd.acc_clear = 1'b1;
                     idx_in        = '0;
                     state_in      = (status.count == '0) ? S_MAG : S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_ZSUM;
         end
         S_ZSUM: begin
            cmd.zsum = 1'b1;
            state_in = S_SIG;
         end
         S_SIG: begin
            cmd.sig  = 1'b1;
            state_in = S_GRAD1;
         end
         S_GRAD1: begin
            cmd.grad1 = 1'b1;
            state_in  = S_GRAD2;
         end
         S_GRAD2: begin
            cmd.grad2 = 1'b1;
            it_in     = '0;
            state_in  = S_LOGIT;
         end
         S_LOGIT: begin
            cmd.log_iter = 1'b1;
            it_in        = it_ff + 1'b1;
            if (it_ff == ITER_W'(LOG_ITERS - 1)) state_in = S_LOGACC;
         end
         S_LOGACC: begin
            cmd.log_acc = 1'b1;
            idx_in      = idx_ff + 1'b1;
            state_in    = (idx_in == status.count) ? S_MAG : S_READ;
         end
         S_MAG: begin
            cmd.mag_init = 1'b1;
            state_in     = S_SHIFT;
         end
         S_SHIFT: begin
            if (status.grad_zero) begin
               state_in = S_OUT;
            end else if (status.max_big) begin
               cmd.mag_shift = 1'b1;
            end else begin
               sel_in   = 2'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq_acc = 1'b1;
            sel_in     = sel_ff + 1'b1;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_SQRTI;
            end
         end
         S_SQRTI: begin
            cmd.sqrt_init = 1'b1;
            it_in         = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_iter = 1'b1;
            it_in         = it_ff + 1'b1;
            if (it_ff == ITER_W'(SQRT_ITERS - 1)) state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            it_in        = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_iter = 1'b1;
            it_in        = it_ff + 1'b1;
            if (it_ff == ITER_W'(DIV_ITERS - 1)) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            if (sel_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = S_DIVI;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         it_ff        <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         it_ff        <= it_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/lrgd_dp.sv -----
// ----------------------------------------------------------------------------
// lrgd_dp
// Point memory, weights, configuration registers and the arithmetic units:
// logit, sigmoid segments, gradient and cost sums, norm and step division.
// ----------------------------------------------------------------------------
module lrgd_dp import lrgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lrgd_cmd_type       cmd,
   output lrgd_status_type    status,
   input  logic signed [15:0] req_feature_one,
   input  logic signed [15:0] req_feature_two,
   input  logic               req_label,
   input  logic               csr_wen,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic signed [31:0] rsp_weight_bias,
   output logic signed [31:0] rsp_weight_one,
   output logic signed [31:0] rsp_weight_two,
   output logic [31:0]        rsp_total_cost
);

   function automatic logic [4:0] shift_to_norm(input logic [15:0] q);
      logic [4:0] n;
      n = 5'd16;
      for (int k = 0; k < 16; k++) begin
         if (q[k]) n = 5'(16 - k);
      end
      return n;
   endfunction

   // configuration and control state
   logic [15:0]        lr_ff;
   logic signed [31:0] iw0_ff, iw1_ff, iw2_ff;
   logic signed [31:0] w0_ff, w1_ff, w2_ff;
   logic [CNT_W-1:0]   count_ff;

   // payload state
   logic [32:0]              mem [MAX_POINTS];
   logic [32:0]              rd_ff;
   logic signed [47:0]       p1_ff, p2_ff;
   logic signed [49:0]       z_ff;
   logic [15:0]              h_ff;
   logic signed [GRAD_W-1:0] g0_ff, g1_ff, g2_ff;
   logic [COST_W-1:0]        cost_ff;
   logic [16:0]              m_ff;
   logic [4:0]               n_ff;
   logic [15:0]              frac_ff;
   logic [GRAD_W-1:0]        mag0_ff, mag1_ff, mag2_ff;
   logic [61:0]              sq_ff;
   logic [63:0]              v_ff, res_ff, sqbit_ff;
   logic [53:0]              num_ff;
   logic [31:0]              rem_ff;
   logic signed [31:0]       ow0_ff, ow1_ff, ow2_ff;
   logic [31:0]              ocost_ff;

   logic signed [15:0] x1, x2;
   logic               y;
   logic               full;

   assign x1   = rd_ff[15:0];
   assign x2   = rd_ff[31:16];
   assign y    = rd_ff[32];
   assign full = (count_ff == CNT_W'(MAX_POINTS));

   // sigmoid segments on |z| in Q.16
   logic [49:0] z_abs;
   logic [33:0] a;
   logic [16:0] sy;
   logic [15:0] h_in;
   always_comb begin
      z_abs = z_ff[49] ? 50'(-z_ff) : 50'(z_ff);
      a     = z_abs[49:16];
      if (a >= 34'd327680)      sy = 17'd65536;
      else if (a >= 34'd155648) sy = 17'(a >> 5) + 17'd55296;
      else if (a >= 34'd65536)  sy = 17'(a >> 3) + 17'd40960;
      else                      sy = 17'(a >> 2) + 17'd32768;
      if (z_ff[49]) sy = 17'd65536 - sy;
      if (sy == 17'd0)          h_in = 16'd1;
      else if (sy[16])          h_in = 16'd65535;
      else                      h_in = sy[15:0];
   end

   logic signed [17:0] e;
   logic signed [33:0] ex1, ex2;
   logic [15:0]        q;
   assign e   = $signed({2'b00, h_ff}) - (y ? 18'sd65536 : 18'sd0);
   assign ex1 = e * x1;
   assign ex2 = e * x2;
   assign q   = y ? h_ff : 16'(17'd65536 - {1'b0, h_ff});

   // log2 by repeated squaring
   logic [33:0] msq;
   logic [17:0] msh;
   assign msq = m_ff * m_ff;
   assign msh = msq[33:16];

   logic [20:0] lg;
   logic [36:0] lprod;
   assign lg    = {n_ff, 16'h0000} - {5'b00000, frac_ff};
   assign lprod = lg * LN2_Q16;

   // magnitudes and selection by gradient index
   logic [GRAD_W-1:0] mag_sel;
   logic signed [GRAD_W-1:0] g_sel;
   logic signed [31:0] w_sel;
   always_comb begin
      case (cmd.sel)
         2'd0:    begin mag_sel = mag0_ff; g_sel = g0_ff; w_sel = w0_ff; end
         2'd1:    begin mag_sel = mag1_ff; g_sel = g1_ff; w_sel = w1_ff; end
         default: begin mag_sel = mag2_ff; g_sel = g2_ff; w_sel = w2_ff; end
      endcase
   end

   logic [59:0] mag_sq;
   assign mag_sq = mag_sel[29:0] * mag_sel[29:0];

   logic [63:0] sq_trial;
   assign sq_trial = res_ff + sqbit_ff;

   logic [45:0] lr_mag;
   logic [32:0] div_trial;
   logic        div_ge;
   assign lr_mag    = lr_ff * mag_sel[29:0];
   assign div_trial = {rem_ff, num_ff[53]};
   assign div_ge    = (div_trial >= {1'b0, res_ff[31:0]});

   // weight step with saturation
   logic signed [55:0] wx, dx, nw;
   logic signed [31:0] w_new;
   always_comb begin
      wx = 56'(w_sel);
      dx = $signed({2'b00, num_ff});
      nw = g_sel[GRAD_W-1] ? wx + dx : wx - dx;
      if (nw > 56'sd2147483647)       w_new = 32'sh7FFFFFFF;
      else if (nw < -56'sd2147483648) w_new = 32'sh80000000;
      else                            w_new = nw[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= LEARN_RATE_RESET;
         iw0_ff   <= INIT_WEIGHT_RESET;
         iw1_ff   <= INIT_WEIGHT_RESET;
         iw2_ff   <= INIT_WEIGHT_RESET;
         w0_ff    <= INIT_WEIGHT_RESET;
         w1_ff    <= INIT_WEIGHT_RESET;
         w2_ff    <= INIT_WEIGHT_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_LEARN_RATE: lr_ff  <= csr_wdata[15:0];
               CSR_INIT_BIAS:  iw0_ff <= csr_wdata;
               CSR_INIT_ONE:   iw1_ff <= csr_wdata;
               CSR_INIT_TWO:   iw2_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load && !full) count_ff <= count_ff + 1'b1;
         if (cmd.clear) begin
            count_ff <= '0;
            w0_ff    <= iw0_ff;
            w1_ff    <= iw1_ff;
            w2_ff    <= iw2_ff;
         end
         if (cmd.update) begin
            case (cmd.sel)
               2'd0:    w0_ff <= w_new;
               2'd1:    w1_ff <= w_new;
               default: w2_ff <= w_new;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full)
         mem[count_ff[ADDR_W-1:0]] <= {req_label, req_feature_two, req_feature_one};
      if (cmd.mem_read) rd_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) p1_ff <= w1_ff * x1;
      if (cmd.mul2) p2_ff <= w2_ff * x2;
      if (cmd.zsum) z_ff <= 50'(w0_ff) * 50'sd256 + 50'(p1_ff) + 50'(p2_ff);
      if (cmd.sig)  h_ff <= h_in;
      if (cmd.acc_clear) begin
         g0_ff   <= '0;
         g1_ff   <= '0;
         g2_ff   <= '0;
         cost_ff <= '0;
      end
      if (cmd.grad1) begin
         g0_ff   <= g0_ff + GRAD_W'(e) * GRAD_W'(256);
         g1_ff   <= g1_ff + GRAD_W'(ex1);
         n_ff    <= shift_to_norm(q);
         m_ff    <= 17'({1'b0, q} << shift_to_norm(q));
         frac_ff <= '0;
      end
      if (cmd.grad2) g2_ff <= g2_ff + GRAD_W'(ex2);
      if (cmd.log_iter) begin
         m_ff    <= msh[17] ? msh[17:1] : msh[16:0];
         frac_ff <= {frac_ff[14:0], msh[17]};
      end
      if (cmd.log_acc) cost_ff <= cost_ff + COST_W'(lprod[36:16]);
      if (cmd.mag_init) begin
         mag0_ff <= g0_ff[GRAD_W-1] ? GRAD_W'(-g0_ff) : GRAD_W'(g0_ff);
         mag1_ff <= g1_ff[GRAD_W-1] ? GRAD_W'(-g1_ff) : GRAD_W'(g1_ff);
         mag2_ff <= g2_ff[GRAD_W-1] ? GRAD_W'(-g2_ff) : GRAD_W'(g2_ff);
         sq_ff   <= '0;
      end
      if (cmd.mag_shift) begin
         mag0_ff <= mag0_ff >> 1;
         mag1_ff <= mag1_ff >> 1;
         mag2_ff <= mag2_ff >> 1;
      end
      if (cmd.sq_acc) sq_ff <= sq_ff + 62'(mag_sq);
      if (cmd.sqrt_init) begin
         v_ff     <= 64'(sq_ff);
         res_ff   <= '0;
         sqbit_ff <= 64'h4000_0000_0000_0000;
      end
      if (cmd.sqrt_iter) begin
         if (v_ff >= sq_trial) begin
            v_ff   <= v_ff - sq_trial;
            res_ff <= (res_ff >> 1) + sqbit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         sqbit_ff <= sqbit_ff >> 2;
      end
      if (cmd.div_init) begin
         num_ff <= {lr_mag, 8'h00};
         rem_ff <= '0;
      end
      if (cmd.div_iter) begin
         rem_ff <= div_ge ? 32'(div_trial - {1'b0, res_ff[31:0]}) : div_trial[31:0];
         num_ff <= {num_ff[52:0], div_ge};
      end
      if (cmd.out_load) begin
         ow0_ff   <= w0_ff;
         ow1_ff   <= w1_ff;
         ow2_ff   <= w2_ff;
         ocost_ff <= (|cost_ff[COST_W-1:32]) ? 32'hFFFF_FFFF : cost_ff[31:0];
      end
   end

   assign status.count     = count_ff;
   assign status.max_big   = (|mag0_ff[GRAD_W-1:30]) | (|mag1_ff[GRAD_W-1:30])
                           | (|mag2_ff[GRAD_W-1:30]);
   assign status.grad_zero = (mag0_ff == '0) && (mag1_ff == '0) && (mag2_ff == '0);

   assign rsp_weight_bias = ow0_ff;
   assign rsp_weight_one  = ow1_ff;
   assign rsp_weight_two  = ow2_ff;
   assign rsp_total_cost  = ocost_ff;

endmodule

// ----- sv/logistic_regression_gd_step.sv -----
// Load and clear words complete in the idle state; a step word walks each stored
// point, then applies s (0..11) gradient prescale shifts before the norm.
// Per point the 16-round squaring log2 dominates; the tail is set by the
// 32-round square root and three 54-round restoring divisions.
// Throughput: one step word at a time; the result register frees the input.
// Synchronous reset empties the point set and loads the default weights.
// ----------------------------------------------------------------------------
// logistic_regression_gd_step
// Two-feature logistic regression trainer: stores points, runs one epoch of
// normalized gradient descent per step word and returns weights and cost.
// ----------------------------------------------------------------------------
module logistic_regression_gd_step import lrgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_feature_one,
   input  logic signed [15:0] req_feature_two,
   input  logic               req_label,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_weight_bias,
   output logic signed [31:0] rsp_weight_one,
   output logic signed [31:0] rsp_weight_two,
   output logic [31:0]        rsp_total_cost,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   lrgd_cmd_type    cmd;
   lrgd_status_type status;

   // registers accept a write on any cycle
   assign csr_ready = 1'b1;

   // sequence each word and hand out per-cycle commands
   lrgd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // hold points, weights and all arithmetic
   lrgd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_feature_one (req_feature_one),
      .req_feature_two (req_feature_two),
      .req_label       (req_label),
      .csr_wen         (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_weight_bias (rsp_weight_bias),
      .rsp_weight_one  (rsp_weight_one),
      .rsp_weight_two  (rsp_weight_two),
      .rsp_total_cost  (rsp_total_cost)
   );

   // a step word blocks further requests on the next cycle
   a_step_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_STEP) |=> req_stall)
      else $error("step word did not block the request channel");

   // a result only appears at the end of a step, while requests are blocked
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word raised outside a step");

endmodule

// ----- tb/logistic_regression_gd_step_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_regression_gd_step_tb
// Drives load, clear and step words into the gradient step block, predicts
// weights and cost with a fixed-point model of one training epoch, and
// compares every result word field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module logistic_regression_gd_step_tb;
   import lrgd_pkg::*;

   typedef struct {
      logic [31:0] wb;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] cost;
   } step_result_type;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] f1;
      logic [15:0] f2;
      logic        lbl;
      bit          typed;
      logic [31:0] cost;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_LOAD;
   logic signed [15:0] req_feature_one = '0;
   logic signed [15:0] req_feature_two = '0;
   logic               req_label = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [31:0] rsp_weight_bias;
   logic signed [31:0] rsp_weight_one;
   logic signed [31:0] rsp_weight_two;
   logic [31:0]        rsp_total_cost;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_LEARN_RATE;
   logic [31:0]        csr_wdata = '0;

   // Predictor state, mirrors the block's registers and point memory
   logic [15:0]        alpha_q16;
   logic [31:0]        init_w [3];
   longint             theta [3];
   logic [15:0]        pts_x1 [MAX_POINTS];
   logic [15:0]        pts_x2 [MAX_POINTS];
   logic               pts_y [MAX_POINTS];
   int                 pts_n;

   step_result_type    pending_results [$];
   // optional typed cost: bit 32 set means "check cost against typed value"
   logic [32:0]        typed_costs [$];
   int                 mismatches = 0;
   bit                 hold_off = 1'b0;

   logistic_regression_gd_step uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Fixed-point model of one epoch
   // ------------------------------------------------------------------------
   function automatic longint unsigned sigmoid_q16(longint z);
      longint unsigned a, y;
      a = (z < 0) ? -z : z;
      a = a >> 16;
      if (a >= 5 * 65536)      y = 65536;
      else if (a >= 155648)    y = (a >> 5) + 55296;
      else if (a >= 65536)     y = (a >> 3) + 40960;
      else                     y = (a >> 2) + 32768;
      if (z < 0) y = 65536 - y;
      if (y < 1) y = 1;
      if (y > 65535) y = 65535;
      return y;
   endfunction

   function automatic longint unsigned neg_ln_q16(longint unsigned v);
      longint unsigned m, frac, n;
      m = v; frac = 0; n = 0;
      while (m < 65536) begin
         m = m << 1;
         n++;
      end
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 16;
         frac = frac << 1;
         if (m >= 131072) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return ((n * 65536 - frac) * 45426) >> 16;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void reload_theta();
      for (int j = 0; j < 3; j++) theta[j] = longint'($signed(init_w[j]));
   endfunction

   // Apply one accepted request word; push the predicted weights and cost
   function automatic void train_word(logic [1:0] op, logic [15:0] f1, logic [15:0] f2,
                                      logic lbl);
      longint grad [3];
      longint unsigned mag [3];
      longint unsigned cost, maxm, sq, norm, h;
      longint x1, x2, z, e, d, w;
      int s;
      step_result_type r;
      grad = '{0, 0, 0};
      cost = 0; maxm = 0; sq = 0; s = 0;
      case (op)
         OP_LOAD: begin
            if (pts_n < MAX_POINTS) begin
               pts_x1[pts_n] = f1;
               pts_x2[pts_n] = f2;
               pts_y[pts_n]  = lbl;
               pts_n++;
            end
         end
         OP_CLEAR: begin
            pts_n = 0;
            reload_theta();
         end
         OP_STEP: begin
            for (int i = 0; i < pts_n; i++) begin
               x1 = longint'($signed(pts_x1[i]));
               x2 = longint'($signed(pts_x2[i]));
               z = theta[0] * 256 + theta[1] * x1 + theta[2] * x2;
               h = sigmoid_q16(z);
               e = longint'(h) - (pts_y[i] ? 65536 : 0);
               grad[0] += e * 256;
               grad[1] += e * x1;
               grad[2] += e * x2;
               cost += neg_ln_q16(pts_y[i] ? h : 65536 - h);
            end
            if (cost > 64'hFFFF_FFFF) cost = 64'hFFFF_FFFF;
            for (int j = 0; j < 3; j++) begin
               mag[j] = (grad[j] < 0) ? -grad[j] : grad[j];
               if (mag[j] > maxm) maxm = mag[j];
            end
            if (maxm != 0) begin
               while ((maxm >> s) >= (64'd1 << 30)) s++;
               for (int j = 0; j < 3; j++) begin
                  mag[j] = mag[j] >> s;
                  sq += mag[j] * mag[j];
               end
               norm = root_floor(sq);
               for (int j = 0; j < 3; j++) begin
                  d = longint'((longint'(alpha_q16) * mag[j] * 256) / norm);
                  w = (grad[j] < 0) ? theta[j] + d : theta[j] - d;
                  if (w > 64'sd2147483647) w = 64'sd2147483647;
                  if (w < -64'sd2147483648) w = -64'sd2147483648;
                  theta[j] = w;
               end
            end
            r.wb = theta[0][31:0];
            r.w1 = theta[1][31:0];
            r.w2 = theta[2][31:0];
            r.cost = cost[31:0];
            pending_results.push_back(r);
         end
         default: ;  // unknown opcode: drop
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checker: stall at random, compare against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic report(string name, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h actual %h", name, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            step_result_type r;
            logic [32:0] tc;
            r = pending_results.pop_front();
            tc = typed_costs.pop_front();
            if (rsp_weight_bias !== r.wb) report("weight_bias", r.wb, rsp_weight_bias);
            if (rsp_weight_one !== r.w1)  report("weight_one", r.w1, rsp_weight_one);
            if (rsp_weight_two !== r.w2)  report("weight_two", r.w2, rsp_weight_two);
            if (rsp_total_cost !== r.cost) report("total_cost", r.cost, rsp_total_cost);
            // typed row: also hold the predictor to the hand-read value
            if (tc[32] && tc[31:0] !== r.cost) report("typed cost", tc[31:0], r.cost);
         end
      end
   end

   // Receiver idling: mostly short gaps, some long, occasional hold-off
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_stall <= 1'b1;
      else if ($urandom_range(0, 9) < 6)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 19) != 0) ? 1'b1 : 1'b0;
   end

   // Long hold-off counted here, while the sender keeps offering words
   initial begin
      int n;
      wait (!reset);
      repeat (400) @(posedge clock);
      hold_off = 1'b1;
      n = 0;
      while (n < 3000) begin
         @(posedge clock);
         n++;
      end
      hold_off = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------
   task automatic send_word(logic [1:0] op, logic [15:0] f1, logic [15:0] f2, logic lbl,
                            logic [32:0] tc);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // drop valid only when idling; back to back words keep it high
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_feature_one <= f1;
      req_feature_two <= f2;
      req_label       <= lbl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: advance the predictor
      if (op == OP_STEP) typed_costs.push_back(tc);
      train_word(op, f1, f2, lbl);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEARN_RATE: alpha_q16 = val[15:0];
         CSR_INIT_BIAS:  init_w[0] = val;
         CSR_INIT_ONE:   init_w[1] = val;
         default:        init_w[2] = val;
      endcase
      @(posedge clock);
   endtask

   // Wait until every prediction has been matched, then let the tail drain
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_phase(int items);
      int r, pts;
      pts = 0;
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            // small-magnitude features mostly, full range sometimes
            if ($urandom_range(0, 4) == 0)
               send_word(OP_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), '0);
            else
               send_word(OP_LOAD, 16'($signed($urandom_range(0, 2047)) - 1024),
                         16'($signed($urandom_range(0, 2047)) - 1024), 1'($urandom), '0);
            pts++;
         end else if (r < 90) begin
            send_word(OP_STEP, 16'($urandom), 16'($urandom), 1'($urandom), '0);
         end else if (r < 96 || pts > 30) begin
            send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), '0);
            pts = 0;
         end else begin
            send_word(2'd3, 16'($urandom), 16'($urandom), 1'($urandom), '0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Directed table, then random phases under several register settings
   // ------------------------------------------------------------------------
   row_type rows [] = '{
      // step on an empty set: zero gradient, zero cost
      '{OP_STEP,  16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0},
      '{OP_LOAD,  16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 32'd0},
      '{OP_LOAD,  16'h8000, 16'h8000, 1'b0, 1'b0, 32'd0},
      '{OP_LOAD,  16'h0000, 16'h0000, 1'b1, 1'b0, 32'd0},
      '{OP_LOAD,  16'hFFFF, 16'h0001, 1'b0, 1'b0, 32'd0},
      '{OP_LOAD,  16'h5555, 16'hAAAA, 1'b1, 1'b0, 32'd0},
      '{OP_STEP,  16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
      '{OP_STEP,  16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
      '{2'd3,     16'h1234, 16'h4321, 1'b1, 1'b0, 32'd0},
      '{OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
      '{OP_STEP,  16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0},
      '{OP_LOAD,  16'h0100, 16'hFF00, 1'b0, 1'b0, 32'd0},
      '{OP_LOAD,  16'hFF00, 16'h0100, 1'b1, 1'b0, 32'd0},
      '{OP_STEP,  16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
      '{OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'd0}
   };

   initial begin
      alpha_q16 = LEARN_RATE_RESET;
      for (int j = 0; j < 3; j++) init_w[j] = INIT_WEIGHT_RESET;
      reload_theta();
      pts_n = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_word(rows[i].op, rows[i].f1, rows[i].f2, rows[i].lbl,
                   {rows[i].typed, rows[i].cost});
      drain();

      // Extreme settings: max rate, extreme initial weights
      write_reg(CSR_LEARN_RATE, 32'h0000_FFFF);
      write_reg(CSR_INIT_BIAS, 32'h7FFF_FFFF);
      write_reg(CSR_INIT_ONE, 32'h8000_0000);
      write_reg(CSR_INIT_TWO, 32'h0000_0000);
      send_word(OP_CLEAR, '0, '0, 1'b0, '0);
      random_phase(30);
      drain();

      // Zero rate: weights never move
      write_reg(CSR_LEARN_RATE, 32'h0000_0000);
      write_reg(CSR_INIT_BIAS, 32'h8000_0000);
      write_reg(CSR_INIT_ONE, 32'h7FFF_FFFF);
      write_reg(CSR_INIT_TWO, 32'hFFFF_FFFF);
      send_word(OP_CLEAR, '0, '0, 1'b0, '0);
      random_phase(25);
      drain();

      // Random settings
      write_reg(CSR_LEARN_RATE, $urandom);
      write_reg(CSR_INIT_BIAS, $urandom);
      write_reg(CSR_INIT_ONE, $urandom);
      write_reg(CSR_INIT_TWO, $urandom);
      send_word(OP_CLEAR, '0, '0, 1'b0, '0);
      random_phase(30);
      drain();

      // Back to modest weights for deeper training runs
      write_reg(CSR_LEARN_RATE, 32'd6554);
      write_reg(CSR_INIT_BIAS, 32'h0000_0000);
      write_reg(CSR_INIT_ONE, 32'h0100_0000);
      write_reg(CSR_INIT_TWO, 32'hFF00_0000);
      send_word(OP_CLEAR, '0, '0, 1'b0, '0);
      random_phase(30);
      drain();

      if (mismatches == 0)
         $display("logistic_regression_gd_step test passed");
      else
         $display("logistic_regression_gd_step test failed");
      $finish;
   end

   // Hard limit: slowest run is well under a few million ns
   initial begin
      #40_000_000;
      $display("logistic_regression_gd_step test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/lrgd_pkg.sv
sv/lrgd_ctrl.sv
sv/lrgd_dp.sv
sv/logistic_regression_gd_step.sv
tb/logistic_regression_gd_step_tb.sv
